// ===== design/app_pkg.sv =====
package app_pkg;

   // Tap count and derived widths
   localparam int NUM_TAPS   = 3;
   localparam int TAP_W      = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int STEP_W     = 16;
   localparam int P_W        = 32;
   localparam int PK_SHIFT   = 30;
   localparam int PK_W       = PK_SHIFT + NUM_TAPS;
   localparam int GAIN_W     = 48;
   localparam int WIDE_W     = 64;
   localparam int ERR_W      = 32;
   localparam int PH_W       = 32;
   localparam int PH_SHIFT   = 22;
   localparam int U_SHIFT    = 17;
   localparam int D_SHIFT    = 16;
   localparam int ERR_SHIFT  = 20;

   // Shared multiplier: OP_W x OP_W signed, DIG_W bits of operand b per cycle
   localparam int OP_W       = 48;
   localparam int DIG_W      = 16;
   localparam int MUL_DIGITS = OP_W / DIG_W;
   localparam int DIG_IDX_W  = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);
   localparam int PROD_W     = 2 * OP_W;

   localparam logic signed [COEF_W-1:0] ONE_Q28 = COEF_W'(32'sd268435456);
   localparam logic [PK_W-1:0]          ONE_Q30 = PK_W'(1) << PK_SHIFT;

   typedef struct packed {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
      logic signed [SAMPLE_W-1:0] ref_i;
      logic signed [SAMPLE_W-1:0] ref_q;
      logic                       block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_i;
      logic signed [SAMPLE_W-1:0] out_q;
      logic                       out_end;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

// ===== design/app_mul.sv =====
module app_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [app_pkg::OP_W-1:0]     op_a,
   input  logic signed [app_pkg::OP_W-1:0]     op_b,
   output app_pkg::mul_sts_type                sts,
   output logic signed [app_pkg::PROD_W-1:0]   prod
);

   localparam int PP_W = app_pkg::OP_W + app_pkg::DIG_W + 1;

   logic signed [app_pkg::OP_W-1:0]      a_ff, a_in;
   logic signed [app_pkg::OP_W-1:0]      b_ff, b_in;
   logic signed [app_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [app_pkg::MUL_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [app_pkg::DIG_IDX_W-1:0]        idx;
   logic signed [app_pkg::DIG_W:0]       digit;
   logic signed [PP_W-1:0]               pp;

   // Pick the next digit of b, most significant first; only the top one is signed
   always_comb begin
      idx   = app_pkg::DIG_IDX_W'(cnt_ff - 1'b1);
      digit = {(idx == app_pkg::DIG_IDX_W'(app_pkg::MUL_DIGITS - 1)) ?
               b_ff[app_pkg::OP_W-1] : 1'b0,
               b_ff[idx*app_pkg::DIG_W +: app_pkg::DIG_W]};
      pp    = a_ff * digit;
   end

   // Shift and accumulate one partial product per cycle
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = app_pkg::MUL_CNT_W'(app_pkg::MUL_DIGITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< app_pkg::DIG_W) + app_pkg::PROD_W'(pp);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == app_pkg::MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign prod     = acc_ff;

   // Checks
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("multiplier restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("multiplier done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff || $past(start)) else $error("done held");

endmodule

// ===== design/adaptive_polynomial_predistorter.sv =====
// Apply runs from accept to result; adapt then updates every tap after the result.
// Only one transaction is in flight at a time; every product is issued to the single
// shared multiplier, which steps through the operand digits of b and hands the
// product back before the next product is issued.
// Reset (synchronous, active high): taps return to identity, step size to zero.
module adaptive_polynomial_predistorter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  app_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output app_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [app_pkg::STEP_W-1:0]    csr_write_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_P1, S_P2, S_GR, S_GI, S_PK, S_V1, S_V2, S_V3, S_V4,
      S_EMIT, S_ERR, S_PHR, S_PHQ, S_U1, S_U2, S_U3, S_U4, S_D1, S_D2
   } state_type;

   localparam logic [app_pkg::TAP_W-1:0] LAST_TAP = app_pkg::TAP_W'(app_pkg::NUM_TAPS - 1);

   state_type                               state_ff, state_in;
   logic                                    issued_ff, issued_in;
   logic [app_pkg::TAP_W-1:0]               tap_ff, tap_in;
   logic                                    mode_ff, mode_in;
   logic                                    end_ff, end_in;
   logic signed [app_pkg::SAMPLE_W-1:0]     si_ff, si_in, sq_ff, sq_in;
   logic signed [app_pkg::SAMPLE_W-1:0]     xi_ff, xi_in, xq_ff, xq_in;
   logic [app_pkg::P_W-1:0]                 p_ff, p_in;
   logic [app_pkg::PK_W-1:0]                pk_ff [app_pkg::NUM_TAPS];
   logic [app_pkg::PK_W-1:0]                pk_in [app_pkg::NUM_TAPS];
   logic signed [app_pkg::GAIN_W-1:0]       gr_ff, gr_in, gi_ff, gi_in;
   logic signed [app_pkg::WIDE_W-1:0]       tmp_ff, tmp_in;
   logic signed [app_pkg::WIDE_W-1:0]       vr_ff, vr_in, vi_ff, vi_in;
   logic signed [app_pkg::WIDE_W-1:0]       ur_ff, ur_in, ui_ff, ui_in;
   logic signed [app_pkg::ERR_W-1:0]        er_ff, er_in, ei_ff, ei_in;
   logic signed [app_pkg::PH_W-1:0]         phr_ff, phr_in, phq_ff, phq_in;
   logic signed [app_pkg::COEF_W-1:0]       cr_ff [app_pkg::NUM_TAPS];
   logic signed [app_pkg::COEF_W-1:0]       cr_in [app_pkg::NUM_TAPS];
   logic signed [app_pkg::COEF_W-1:0]       ci_ff [app_pkg::NUM_TAPS];
   logic signed [app_pkg::COEF_W-1:0]       ci_in [app_pkg::NUM_TAPS];
   logic [app_pkg::STEP_W-1:0]              step_ff, step_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   app_pkg::rsp_type                        rsp_data_ff, rsp_data_in;

   logic                                    mul_start;
   logic signed [app_pkg::OP_W-1:0]         op_a, op_b;
   app_pkg::mul_sts_type                    mul_sts;
   logic signed [app_pkg::PROD_W-1:0]       m;
   logic                                    is_op, fire;

   app_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (op_a),
      .op_b  (op_b),
      .sts   (mul_sts),
      .prod  (m)
   );

   // Round a Q.28 value half away from zero, saturate to 16 bits
   function automatic logic signed [app_pkg::SAMPLE_W-1:0] round_sat(
      input logic signed [app_pkg::WIDE_W-1:0] v);
      logic [app_pkg::WIDE_W-1:0] mag;
      logic [35:0]                r;
      mag = v[app_pkg::WIDE_W-1] ? app_pkg::WIDE_W'(-v) : app_pkg::WIDE_W'(v);
      r   = 36'((mag + app_pkg::WIDE_W'(134217728)) >> 28);
      if (v[app_pkg::WIDE_W-1])
         round_sat = (r > 36'd32768) ? 16'sh8000 : app_pkg::SAMPLE_W'(-r);
      else
         round_sat = (r > 36'd32767) ? 16'sh7fff : r[15:0];
   endfunction

   // Error reduced to Q.8 and saturated to 32 bits
   function automatic logic signed [app_pkg::ERR_W-1:0] err_q8(
      input logic signed [app_pkg::SAMPLE_W-1:0] x,
      input logic signed [app_pkg::WIDE_W-1:0]   v);
      logic signed [app_pkg::WIDE_W:0] big;
      logic [44:0]                     e;
      big = (65'($signed({x, 28'd0}))) - 65'(v);
      e   = big[64:20];
      if (!(&e[44:31]) && (|e[44:31]))
         err_q8 = e[44] ? 32'sh80000000 : 32'sh7fffffff;
      else
         err_q8 = e[31:0];
   endfunction

   // Add a tap correction and saturate to 32 bits
   function automatic logic signed [app_pkg::COEF_W-1:0] tap_add(
      input logic signed [app_pkg::COEF_W-1:0] c,
      input logic signed [47:0]                d);
      logic signed [48:0] s;
      s = 49'(c) + 49'(d);
      if (!(&s[48:31]) && (|s[48:31]))
         tap_add = s[48] ? 32'sh80000000 : 32'sh7fffffff;
      else
         tap_add = s[31:0];
   endfunction

   // Select multiplier operands for the current step
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_P1:  begin op_a = app_pkg::OP_W'(si_ff); op_b = app_pkg::OP_W'(si_ff); end
         S_P2:  begin op_a = app_pkg::OP_W'(sq_ff); op_b = app_pkg::OP_W'(sq_ff); end
         S_GR:  begin
            op_a = app_pkg::OP_W'(cr_ff[tap_ff]);
            op_b = $signed(app_pkg::OP_W'(pk_ff[tap_ff]));
         end
         S_GI:  begin
            op_a = app_pkg::OP_W'(ci_ff[tap_ff]);
            op_b = $signed(app_pkg::OP_W'(pk_ff[tap_ff]));
         end
         S_PK:  begin
            op_a = $signed(app_pkg::OP_W'(pk_ff[tap_ff]));
            op_b = $signed(app_pkg::OP_W'(p_ff));
         end
         S_V1:  begin op_a = app_pkg::OP_W'(si_ff); op_b = app_pkg::OP_W'(gr_ff); end
         S_V2:  begin op_a = app_pkg::OP_W'(sq_ff); op_b = app_pkg::OP_W'(gi_ff); end
         S_V3:  begin op_a = app_pkg::OP_W'(si_ff); op_b = app_pkg::OP_W'(gi_ff); end
         S_V4:  begin op_a = app_pkg::OP_W'(sq_ff); op_b = app_pkg::OP_W'(gr_ff); end
         S_PHR: begin
            op_a = app_pkg::OP_W'(si_ff);
            op_b = $signed(app_pkg::OP_W'(pk_ff[tap_ff]));
         end
         S_PHQ: begin
            op_a = app_pkg::OP_W'(sq_ff);
            op_b = $signed(app_pkg::OP_W'(pk_ff[tap_ff]));
         end
         S_U1:  begin op_a = app_pkg::OP_W'(er_ff); op_b = app_pkg::OP_W'(phr_ff); end
         S_U2:  begin op_a = app_pkg::OP_W'(ei_ff); op_b = app_pkg::OP_W'(phq_ff); end
         S_U3:  begin op_a = app_pkg::OP_W'(ei_ff); op_b = app_pkg::OP_W'(phr_ff); end
         S_U4:  begin op_a = app_pkg::OP_W'(er_ff); op_b = app_pkg::OP_W'(phq_ff); end
         S_D1:  begin
            op_a = app_pkg::OP_W'($signed(ur_ff[app_pkg::WIDE_W-1:app_pkg::U_SHIFT]));
            op_b = $signed(app_pkg::OP_W'(step_ff));
         end
         S_D2:  begin
            op_a = app_pkg::OP_W'($signed(ui_ff[app_pkg::WIDE_W-1:app_pkg::U_SHIFT]));
            op_b = $signed(app_pkg::OP_W'(step_ff));
         end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // Sequencer: issue one product, wait for it, fold it into the datapath
   always_comb begin
      is_op     = (state_ff != S_IDLE) && (state_ff != S_EMIT) && (state_ff != S_ERR);
      fire      = is_op && issued_ff && mul_sts.done;
      mul_start = is_op && !issued_ff;
      issued_in = is_op && !fire;

      state_in     = state_ff;
      tap_in       = tap_ff;
      mode_in      = mode_ff;
      end_in       = end_ff;
      si_in        = si_ff;
      sq_in        = sq_ff;
      xi_in        = xi_ff;
      xq_in        = xq_ff;
      p_in         = p_ff;
      pk_in        = pk_ff;
      gr_in        = gr_ff;
      gi_in        = gi_ff;
      tmp_in       = tmp_ff;
      vr_in        = vr_ff;
      vi_in        = vi_ff;
      ur_in        = ur_ff;
      ui_in        = ui_ff;
      er_in        = er_ff;
      ei_in        = ei_ff;
      phr_in       = phr_ff;
      phq_in       = phq_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      rsp_data_in  = rsp_data_ff;
      step_in      = csr_write_enable ? csr_write_data : step_ff;

      // drop the result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               end_in   = req_data.block_end;
               si_in    = req_data.sample_i;
               sq_in    = req_data.sample_q;
               xi_in    = req_data.ref_i;
               xq_in    = req_data.ref_q;
               tap_in   = '0;
               gr_in    = '0;
               gi_in    = '0;
               pk_in[0] = app_pkg::ONE_Q30;
               state_in = S_P1;
            end
         end
         S_P1: if (fire) begin
            tmp_in   = m[app_pkg::WIDE_W-1:0];
            state_in = S_P2;
         end
         S_P2: if (fire) begin
            p_in     = tmp_ff[app_pkg::P_W-1:0] + m[app_pkg::P_W-1:0];
            state_in = S_GR;
         end
         S_GR: if (fire) begin
            gr_in    = gr_ff + $signed(m[app_pkg::PK_SHIFT +: app_pkg::GAIN_W]);
            state_in = S_GI;
         end
         S_GI: if (fire) begin
            gi_in    = gi_ff + $signed(m[app_pkg::PK_SHIFT +: app_pkg::GAIN_W]);
            state_in = (tap_ff == LAST_TAP) ? S_V1 : S_PK;
         end
         S_PK: if (fire) begin
            pk_in[tap_ff + 1'b1] = m[app_pkg::PK_SHIFT +: app_pkg::PK_W];
            tap_in   = tap_ff + 1'b1;
            state_in = S_GR;
         end
         S_V1: if (fire) begin
            tmp_in   = m[app_pkg::WIDE_W-1:0];
            state_in = S_V2;
         end
         S_V2: if (fire) begin
            vr_in    = tmp_ff - $signed(m[app_pkg::WIDE_W-1:0]);
            state_in = S_V3;
         end
         S_V3: if (fire) begin
            tmp_in   = m[app_pkg::WIDE_W-1:0];
            state_in = S_V4;
         end
         S_V4: if (fire) begin
            vi_in    = tmp_ff + $signed(m[app_pkg::WIDE_W-1:0]);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.out_i   = round_sat(vr_ff);
               rsp_data_in.out_q   = round_sat(vi_ff);
               rsp_data_in.out_end = end_ff;
               state_in            = mode_ff ? S_ERR : S_IDLE;
            end
         end
         S_ERR: begin
            er_in    = err_q8(xi_ff, vr_ff);
            ei_in    = err_q8(xq_ff, vi_ff);
            tap_in   = '0;
            state_in = S_PHR;
         end
         S_PHR: if (fire) begin
            phr_in   = m[app_pkg::PH_SHIFT +: app_pkg::PH_W];
            state_in = S_PHQ;
         end
         S_PHQ: if (fire) begin
            phq_in   = m[app_pkg::PH_SHIFT +: app_pkg::PH_W];
            state_in = S_U1;
         end
         S_U1: if (fire) begin
            tmp_in   = m[app_pkg::WIDE_W-1:0];
            state_in = S_U2;
         end
         S_U2: if (fire) begin
            ur_in    = tmp_ff + $signed(m[app_pkg::WIDE_W-1:0]);
            state_in = S_U3;
         end
         S_U3: if (fire) begin
            tmp_in   = m[app_pkg::WIDE_W-1:0];
            state_in = S_U4;
         end
         S_U4: if (fire) begin
            ui_in    = tmp_ff - $signed(m[app_pkg::WIDE_W-1:0]);
            state_in = S_D1;
         end
         S_D1: if (fire) begin
            cr_in[tap_ff] = tap_add(cr_ff[tap_ff], $signed(m[app_pkg::D_SHIFT +: 48]));
            state_in      = S_D2;
         end
         S_D2: if (fire) begin
            ci_in[tap_ff] = tap_add(ci_ff[tap_ff], $signed(m[app_pkg::D_SHIFT +: 48]));
            if (tap_ff == LAST_TAP) begin
               state_in = S_IDLE;
            end else begin
               tap_in   = tap_ff + 1'b1;
               state_in = S_PHR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         for (int k = 0; k < app_pkg::NUM_TAPS; k++) begin
            cr_ff[k] <= '0;
            ci_ff[k] <= '0;
         end
         cr_ff[0] <= app_pkg::ONE_Q28;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cr_ff        <= cr_in;
         ci_ff        <= ci_in;
      end
      tap_ff      <= tap_in;
      mode_ff     <= mode_in;
      end_ff      <= end_in;
      si_ff       <= si_in;
      sq_ff       <= sq_in;
      xi_ff       <= xi_in;
      xq_ff       <= xq_in;
      p_ff        <= p_in;
      pk_ff       <= pk_in;
      gr_ff       <= gr_in;
      gi_ff       <= gi_in;
      tmp_ff      <= tmp_in;
      vr_ff       <= vr_in;
      vi_ff       <= vi_in;
      ur_ff       <= ur_in;
      ui_ff       <= ui_in;
      er_ff       <= er_in;
      ei_ff       <= ei_in;
      phr_ff      <= phr_in;
      phq_ff      <= phq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> issued_ff) else $error("product arrived with none issued");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mul_sts.busy) else $error("multiplier busy while idle");
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall) |=> rsp_valid_ff)
      else $error("result not loaded");

endmodule
